>>> rtl/core/nhn_pkg.sv
// Shared widths, defaults and the controller-to-datapath command bundle
// for the 5-smooth number unit. No dependencies.
`default_nettype none
package nhn_pkg;

   localparam int INDEX_W   = 11;
   localparam int WORD_W    = 32;
   localparam int DEF_MAX_N = 1024;

   // store read port select
   localparam logic [1:0] SEL_TWO   = 2'd0;
   localparam logic [1:0] SEL_THREE = 2'd1;
   localparam logic [1:0] SEL_FIVE  = 2'd2;

   typedef struct packed {
      logic       load;       // restart the sequence
      logic       step;       // append the smallest candidate
      logic [1:0] rd_sel;     // which pointer addresses the store read
      logic       cap_two;    // refresh candidate of 2 from read data
      logic       cap_three;  // refresh candidate of 3 from read data
      logic       cap_five;   // refresh candidate of 5 from read data
      logic       emit;       // load the result register
      logic       bad;        // flagged request, result is zero
   } nhn_cmd_type;

endpackage
`default_nettype wire

>>> rtl/core/nhn_datapath.sv
// Sequence store, pointers, candidates and result register.
// Depends on nhn_pkg; driven by nhn_controller commands.
`default_nettype none
module nhn_datapath #(
   parameter int MAX_N = nhn_pkg::DEF_MAX_N
) (
   input  wire logic                      clock,
   input  wire nhn_pkg::nhn_cmd_type      cmd,
   output logic [nhn_pkg::WORD_W-1:0]     rsp_value,
   output logic                           rsp_bad_index
);
   import nhn_pkg::*;

   localparam int AW = (MAX_N > 2) ? $clog2(MAX_N) : 1;

   logic [WORD_W-1:0] store_mem [MAX_N];

   logic [AW-1:0]     widx_ff, widx_in;
   logic [AW-1:0]     ptr_two_ff, ptr_two_in;
   logic [AW-1:0]     ptr_three_ff, ptr_three_in;
   logic [AW-1:0]     ptr_five_ff, ptr_five_in;
   logic [WORD_W-1:0] cand_two_ff, cand_two_in;
   logic [WORD_W-1:0] cand_three_ff, cand_three_in;
   logic [WORD_W-1:0] cand_five_ff, cand_five_in;
   logic [WORD_W-1:0] last_ff, last_in;
   logic              hit_two_ff, hit_two_in;
   logic              hit_three_ff, hit_three_in;
   logic              hit_five_ff, hit_five_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic [WORD_W-1:0] result_ff, result_in;
   logic              bad_ff, bad_in;

   logic [WORD_W-1:0] next_val;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;
   logic [WORD_W+2:0] prod_two, prod_three, prod_five;
   logic [WORD_W-1:0] sat_two, sat_three, sat_five;

   // smallest of the three candidates
   always_comb begin
      next_val = cand_two_ff;
      if (cand_three_ff < next_val) begin
         next_val = cand_three_ff;
      end
      if (cand_five_ff < next_val) begin
         next_val = cand_five_ff;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         SEL_TWO:   rd_addr = ptr_two_ff;
         SEL_THREE: rd_addr = ptr_three_ff;
         SEL_FIVE:  rd_addr = ptr_five_ff;
         default:   rd_addr = ptr_two_ff;
      endcase
   end

   assign prod_two   = {3'b000, rd_data_ff} * (WORD_W+3)'(2);
   assign prod_three = {3'b000, rd_data_ff} * (WORD_W+3)'(3);
   assign prod_five  = {3'b000, rd_data_ff} * (WORD_W+3)'(5);
   assign sat_two    = (|prod_two[WORD_W+2:WORD_W])   ? '1 : prod_two[WORD_W-1:0];
   assign sat_three  = (|prod_three[WORD_W+2:WORD_W]) ? '1 : prod_three[WORD_W-1:0];
   assign sat_five   = (|prod_five[WORD_W+2:WORD_W])  ? '1 : prod_five[WORD_W-1:0];

   always_comb begin
      widx_in       = widx_ff;
      ptr_two_in    = ptr_two_ff;
      ptr_three_in  = ptr_three_ff;
      ptr_five_in   = ptr_five_ff;
      cand_two_in   = cand_two_ff;
      cand_three_in = cand_three_ff;
      cand_five_in  = cand_five_ff;
      last_in       = last_ff;
      hit_two_in    = hit_two_ff;
      hit_three_in  = hit_three_ff;
      hit_five_in   = hit_five_ff;
      result_in     = result_ff;
      bad_in        = bad_ff;
      wr_en         = 1'b0;
      wr_addr       = widx_ff;
      wr_data       = next_val;
      if (cmd.load) begin
         widx_in       = AW'(1);
         ptr_two_in    = '0;
         ptr_three_in  = '0;
         ptr_five_in   = '0;
         cand_two_in   = WORD_W'(2);
         cand_three_in = WORD_W'(3);
         cand_five_in  = WORD_W'(5);
         last_in       = WORD_W'(1);
         wr_en         = 1'b1;
         wr_addr       = '0;
         wr_data       = WORD_W'(1);
      end
      if (cmd.step) begin
         wr_en        = 1'b1;
         last_in      = next_val;
         widx_in      = widx_ff + AW'(1);
         hit_two_in   = (next_val == cand_two_ff);
         hit_three_in = (next_val == cand_three_ff);
         hit_five_in  = (next_val == cand_five_ff);
         ptr_two_in   = ptr_two_ff   + AW'(hit_two_in);
         ptr_three_in = ptr_three_ff + AW'(hit_three_in);
         ptr_five_in  = ptr_five_ff  + AW'(hit_five_in);
      end
      if (cmd.cap_two && hit_two_ff) begin
         cand_two_in = sat_two;
      end
      if (cmd.cap_three && hit_three_ff) begin
         cand_three_in = sat_three;
      end
      if (cmd.cap_five && hit_five_ff) begin
         cand_five_in = sat_five;
      end
      if (cmd.emit) begin
         result_in = cmd.bad ? '0 : last_ff;
         bad_in    = cmd.bad;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      widx_ff       <= widx_in;
      ptr_two_ff    <= ptr_two_in;
      ptr_three_ff  <= ptr_three_in;
      ptr_five_ff   <= ptr_five_in;
      cand_two_ff   <= cand_two_in;
      cand_three_ff <= cand_three_in;
      cand_five_ff  <= cand_five_in;
      last_ff       <= last_in;
      hit_two_ff    <= hit_two_in;
      hit_three_ff  <= hit_three_in;
      hit_five_ff   <= hit_five_in;
      result_ff     <= result_in;
      bad_ff        <= bad_in;
   end

   assign rsp_value     = result_ff;
   assign rsp_bad_index = bad_ff;

endmodule
`default_nettype wire

>>> rtl/core/nhn_controller.sv
// Sequencer for the 5-smooth number unit: handshakes and step schedule.
// Depends on nhn_pkg; commands nhn_datapath.
`default_nettype none
module nhn_controller #(
   parameter int MAX_N = nhn_pkg::DEF_MAX_N
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [nhn_pkg::INDEX_W-1:0]   req_index,
   output logic                               req_stall,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output nhn_pkg::nhn_cmd_type               cmd
);
   import nhn_pkg::*;

   localparam int AW = (MAX_N > 2) ? $clog2(MAX_N) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_STEP  = 3'd1;
   localparam logic [2:0] ST_RD2   = 3'd2;
   localparam logic [2:0] ST_RD3   = 3'd3;
   localparam logic [2:0] ST_RD5   = 3'd4;
   localparam logic [2:0] ST_LAND  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic          bad_ff, bad_in;
   logic          valid_ff, valid_in;
   logic          accept;
   logic          flagged;
   logic          out_free;

   assign accept   = req_valid && !req_stall;
   assign flagged  = (req_index == '0) || (req_index > INDEX_W'(MAX_N));
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      rem_in        = rem_ff;
      bad_in        = bad_ff;
      valid_in      = valid_ff && rsp_stall;
      cmd           = '0;
      cmd.rd_sel    = SEL_TWO;
      cmd.bad       = bad_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               bad_in = flagged;
               rem_in = AW'(req_index - INDEX_W'(1));
               if (flagged) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.load = 1'b1;
                  state_in = (req_index == INDEX_W'(1)) ? ST_DONE : ST_STEP;
               end
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            rem_in   = rem_ff - AW'(1);
            state_in = (rem_ff == AW'(1)) ? ST_DONE : ST_RD2;
         end
         ST_RD2: begin
            cmd.rd_sel = SEL_TWO;
            state_in   = ST_RD3;
         end
         ST_RD3: begin
            cmd.rd_sel  = SEL_THREE;
            cmd.cap_two = 1'b1;
            state_in    = ST_RD5;
         end
         ST_RD5: begin
            cmd.rd_sel    = SEL_FIVE;
            cmd.cap_three = 1'b1;
            state_in      = ST_LAND;
         end
         ST_LAND: begin
            cmd.cap_five = 1'b1;
            state_in     = ST_STEP;
         end
         ST_DONE: begin
            // hold until the result register is free
            if (out_free) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      bad_ff <= bad_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

>>> rtl/core/nth_hamming_number_unit.sv
// Top level of the n-th 5-smooth (Hamming) number unit.
// Depends on nhn_pkg, nhn_controller and nhn_datapath.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_index[10:0]
//   rsp       out         rsp_valid / rsp_stall  rsp_value[31:0], rsp_bad_index
//
// One request at a time. A flagged index (zero or above MAX_N) or an index of
// one goes straight to the done state; otherwise each value comes from a step
// of generation (STEP, RD2, RD3, RD5, LAND) around the single store read port
// (one read per pointer, then the saturating multiply into its candidate).
// Reset is synchronous; it clears the sequencer and the result valid. The
// store needs no clearing: every entry a request reads was written earlier
// in that request. A new request is taken as soon as the sequencer is idle,
// even while a finished result still waits behind rsp_stall.
`default_nettype none
module nth_hamming_number_unit #(
   parameter int MAX_N = nhn_pkg::DEF_MAX_N
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [nhn_pkg::INDEX_W-1:0]   req_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [nhn_pkg::WORD_W-1:0]         rsp_value,
   output logic                               rsp_bad_index
);
   import nhn_pkg::*;

   // command bundle from the sequencer to the datapath
   nhn_cmd_type cmd;

   // sequencer: accepts the request, schedules steps, owns rsp_valid
   nhn_controller #(
      .MAX_N (MAX_N)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_index (req_index),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: sequence store, pointers, candidates, result register
   nhn_datapath #(
      .MAX_N (MAX_N)
   ) u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .rsp_value     (rsp_value),
      .rsp_bad_index (rsp_bad_index)
   );

endmodule
`default_nettype wire
